// ===== src/mglap_pkg.sv =====
// Shared types and constants for the masked gradient / Laplacian stencil.
// Holds the controller state encoding and the controller-to-datapath command
// and status structs. No dependencies.
`default_nettype none

package mglap_pkg;

  localparam int FW_BITS = 11;
  localparam logic [FW_BITS-1:0] FW_RESET = 11'd1024;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_LATER
  } row_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_CALC,
    ST_SQUARE,
    ST_LOAD,
    ST_ROOT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;        // capture the accepted transaction
    logic has_above;   // row above exists
    logic has_right;   // column to the right exists
    logic last;        // final output pixel of the frame
    logic fill;        // first row: write center store only
    logic rd_en;       // read line stores
    logic calc;        // stencil arithmetic, store update
    logic square;      // square the differences
    logic root_start;  // launch square root
    logic out_load;    // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic root_busy;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/mglap_in_if.sv =====
// Input channel: valid/ready handshake carrying one raster transaction.
// Width follows SAMPLE_BITS. No dependencies.
`default_nettype none

interface mglap_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          pixel_valid;

  modport source (output valid, output action, output sample, output pixel_valid,
                  input ready);
  modport sink (input valid, input action, input sample, input pixel_valid,
                output ready);
endinterface

`default_nettype wire

// ===== src/mglap_out_if.sv =====
// Output channel: valid/ready handshake carrying one stencil result.
// Widths follow SAMPLE_BITS. No dependencies.
`default_nettype none

interface mglap_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [SAMPLE_BITS:0]          gradient;
  logic signed [SAMPLE_BITS+2:0] laplacian;
  logic                          masked_out;
  logic                          last_in_frame;

  modport source (output valid, output gradient, output laplacian, output masked_out,
                  output last_in_frame, input ready);
  modport sink (input valid, input gradient, input laplacian, input masked_out,
                input last_in_frame, output ready);
endinterface

`default_nettype wire

// ===== src/mglap_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Floor root of a 2N-bit radicand. No dependencies.
`default_nettype none

module mglap_sqrt #(
  parameter int N = 17
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [2*N-1:0] radicand,
  output logic                busy,
  output logic [N-1:0]        root
);

  localparam int RW = 2 * N;
  localparam int CNT_BITS = $clog2(N + 1);
  localparam logic [RW-1:0] ONE_INIT = {2'b01, {(RW - 2){1'b0}}};

  logic [CNT_BITS-1:0] cnt;
  logic [RW-1:0]       op;
  logic [RW-1:0]       res;
  logic [RW-1:0]       one;
  logic [RW-1:0]       trial;
  logic [RW-1:0]       res_up;
  logic                take;

  assign trial  = res + one;
  assign take   = op >= trial;
  assign res_up = res + {one[RW-2:0], 1'b0};
  assign busy   = cnt != '0;
  assign root   = res[N-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_BITS'(N);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op  <= radicand;
      res <= '0;
      one <= ONE_INIT;
    end else if (busy) begin
      if (take) begin
        op  <= op - trial;
        res <= res_up >> 1;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
    end
  end

endmodule

`default_nettype wire

// ===== src/mglap_ctrl.sv =====
// Controller: frame width register, column and row-phase tracking, and the
// sequencer that steps the datapath. Depends on mglap_pkg.
`default_nettype none

module mglap_ctrl
  import mglap_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         frame_width_we,
  input  wire logic [FW_BITS-1:0]           frame_width_data,
  input  wire logic                         in_valid,
  input  wire logic                         in_action,
  output logic                              in_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output dp_cmd_t                           cmd,
  input  wire dp_sts_t                      sts
);

  localparam int IDX_BITS = $clog2(MAX_WIDTH);
  localparam int CMP_BITS = (IDX_BITS + 1 > FW_BITS) ? IDX_BITS + 1 : FW_BITS;
  localparam logic [CMP_BITS-1:0] MAX_W = CMP_BITS'(MAX_WIDTH);

  state_t              state, state_next;
  row_phase_t          row_phase, row_phase_next;
  logic [IDX_BITS-1:0] column_index, column_index_next;
  logic [FW_BITS-1:0]  frame_width;

  logic [CMP_BITS-1:0] fw_ext;
  logic [CMP_BITS-1:0] width_use;
  logic [CMP_BITS-1:0] col_plus;
  logic                last;

  assign col = column_index;

  // zero width acts as one, oversize acts as the maximum
  always_comb begin
    fw_ext = CMP_BITS'(frame_width);
    priority if (fw_ext == '0) begin
      width_use = CMP_BITS'(1);
    end else if (fw_ext > MAX_W) begin
      width_use = MAX_W;
    end else begin
      width_use = fw_ext;
    end
    col_plus = CMP_BITS'(column_index) + CMP_BITS'(1);
    last     = col_plus >= width_use;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FW_RESET;
    end else if (frame_width_we) begin
      frame_width <= frame_width_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      row_phase    <= PH_FIRST;
      column_index <= '0;
    end else begin
      state        <= state_next;
      row_phase    <= row_phase_next;
      column_index <= column_index_next;
    end
  end

  always_comb begin
    state_next        = state;
    row_phase_next    = row_phase;
    column_index_next = column_index;
    cmd               = '0;
    in_ready          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // a drain before any full row is consumed without effect
        if (in_valid && !(in_action == ACT_DRAIN && row_phase == PH_FIRST)) begin
          cmd.load      = 1'b1;
          cmd.has_above = row_phase == PH_LATER;
          cmd.has_right = !last;
          cmd.last      = (in_action == ACT_DRAIN) && last;
          if (last) begin
            column_index_next = '0;
            if (in_action == ACT_DRAIN) begin
              row_phase_next = PH_FIRST;
            end else if (row_phase == PH_FIRST) begin
              row_phase_next = PH_SECOND;
            end else begin
              row_phase_next = PH_LATER;
            end
          end else begin
            column_index_next = column_index + 1'b1;
          end
          if (in_action == ACT_PIXEL && row_phase == PH_FIRST) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.root_start = 1'b1;
        state_next     = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sts.root_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/mglap_dp.sv =====
// Datapath: above/center line stores, stencil arithmetic, squaring, square
// root unit and output register. Depends on mglap_pkg, mglap_out_if, mglap_sqrt.
`default_nettype none

module mglap_dp
  import mglap_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dp_cmd_t                       cmd,
  output dp_sts_t                            sts,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  col,
  input  wire logic                          in_action,
  input  wire logic [SAMPLE_BITS-1:0]        in_sample,
  input  wire logic                          in_pixel_valid,
  mglap_out_if.source                        out_ch
);

  localparam int SB        = SAMPLE_BITS;
  localparam int IDX_BITS  = $clog2(MAX_WIDTH);
  localparam int ENT_BITS  = SB + 1;
  localparam int GRAD_BITS = SB + 1;
  localparam int LAP_BITS  = SB + 3;
  localparam int SQ_BITS   = 2 * SB;
  localparam int RAD_BITS  = 2 * GRAD_BITS;

  // entry layout: {valid, sample}
  logic [ENT_BITS-1:0] center_mem [MAX_WIDTH];
  logic [ENT_BITS-1:0] above_mem  [MAX_WIDTH];

  logic [IDX_BITS-1:0] col_q;
  logic [IDX_BITS-1:0] col_right;
  logic                is_drain;
  logic [ENT_BITS-1:0] entry_q;
  logic                has_above_q;
  logic                has_right_q;
  logic                last_q;

  logic [ENT_BITS-1:0] center_rd0;
  logic [ENT_BITS-1:0] center_rd1;
  logic [ENT_BITS-1:0] above_rd;
  logic [ENT_BITS-1:0] left_hold;

  logic                center_we;
  logic                above_we;

  logic [ENT_BITS-1:0]       nb_entry [4];
  logic                      nb_pr    [4];
  logic signed [SB-1:0]      gv       [4];
  logic signed [LAP_BITS-1:0] term    [4];
  logic signed [SB-1:0]      cv;
  logic signed [LAP_BITS-1:0] lap_sum;
  logic signed [SB:0]        diff_x;
  logic signed [SB:0]        diff_y;
  logic [SB:0]               mag_x;
  logic [SB:0]               mag_y;

  logic [SB-1:0]             dx;
  logic [SB-1:0]             dy;
  logic signed [LAP_BITS-1:0] lap_q;
  logic                      masked_q;
  logic [SQ_BITS-1:0]        sq_x;
  logic [SQ_BITS-1:0]        sq_y;
  logic [RAD_BITS-1:0]       radicand;
  logic [GRAD_BITS-1:0]      root;
  logic                      root_busy;

  logic                      out_valid;

  assign col_right = col_q + 1'b1;
  assign center_we = (cmd.calc && !is_drain) || cmd.fill;
  assign above_we  = cmd.calc && !is_drain;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q       <= col;
      is_drain    <= in_action == ACT_DRAIN;
      entry_q     <= {in_pixel_valid, in_sample};
      has_above_q <= cmd.has_above;
      has_right_q <= cmd.has_right;
      last_q      <= cmd.last;
    end
  end

  // line stores: one write port, registered reads
  always_ff @(posedge clk) begin
    if (center_we) begin
      center_mem[col_q] <= entry_q;
    end
    if (cmd.rd_en) begin
      center_rd0 <= center_mem[col_q];
      center_rd1 <= center_mem[col_right];
    end
  end

  always_ff @(posedge clk) begin
    if (above_we) begin
      above_mem[col_q] <= center_rd0;
    end
    if (cmd.rd_en) begin
      above_rd <= above_mem[col_q];
    end
  end

  // neighbors: left, right, above, below
  always_comb begin
    cv          = $signed(center_rd0[SB-1:0]);
    nb_entry[0] = left_hold;
    nb_pr[0]    = col_q != '0;
    nb_entry[1] = center_rd1;
    nb_pr[1]    = has_right_q;
    nb_entry[2] = above_rd;
    nb_pr[2]    = has_above_q;
    nb_entry[3] = entry_q;
    nb_pr[3]    = !is_drain;
    for (int k = 0; k < 4; k++) begin
      // gradient: out-of-frame or masked neighbor takes the center value
      if (nb_pr[k] && nb_entry[k][SB]) begin
        gv[k] = $signed(nb_entry[k][SB-1:0]);
      end else begin
        gv[k] = cv;
      end
      // Laplacian: out-of-frame replicates center, masked adds zero
      if (!nb_pr[k]) begin
        term[k] = LAP_BITS'(cv);
      end else if (nb_entry[k][SB]) begin
        term[k] = LAP_BITS'($signed(nb_entry[k][SB-1:0]));
      end else begin
        term[k] = '0;
      end
    end
    lap_sum = term[0] + term[1] + term[2] + term[3] - (LAP_BITS'(cv) <<< 2);
    diff_x  = (SB + 1)'(gv[1]) - (SB + 1)'(gv[0]);
    diff_y  = (SB + 1)'(gv[3]) - (SB + 1)'(gv[2]);
    mag_x   = diff_x[SB] ? (SB + 1)'(-diff_x) : (SB + 1)'(diff_x);
    mag_y   = diff_y[SB] ? (SB + 1)'(-diff_y) : (SB + 1)'(diff_y);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      dx        <= mag_x[SB-1:0];
      dy        <= mag_y[SB-1:0];
      lap_q     <= lap_sum;
      masked_q  <= !center_rd0[SB];
      left_hold <= center_rd0;
    end
    if (cmd.square) begin
      sq_x <= dx * dx;
      sq_y <= dy * dy;
    end
  end

  assign radicand = RAD_BITS'(sq_x) + RAD_BITS'(sq_y);

  mglap_sqrt #(
    .N (GRAD_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (radicand),
    .busy     (root_busy),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.gradient      <= masked_q ? '0 : root;
      out_ch.laplacian     <= masked_q ? '0 : lap_q;
      out_ch.masked_out    <= masked_q;
      out_ch.last_in_frame <= last_q;
    end
  end

  assign out_ch.valid  = out_valid;
  assign sts.out_free  = !out_valid || out_ch.ready;
  assign sts.root_busy = root_busy;

endmodule

`default_nettype wire

// ===== src/masked_gradient_laplacian_stencil.sv =====
// Masked gradient / Laplacian stencil over a raster stream, answering one row
// behind the input. A pixel transaction that yields a result, and every drain
// transaction after a full row, holds the block from the accepting cycle
// through the cycle that loads the result register, stepping through the READ,
// CALC, SQUARE, LOAD, ROOT and FINISH states. Most of that time is the
// bit-serial square root that produces one gradient bit per cycle. A result
// that finds the output register still occupied waits until the sink takes
// the older transaction. A pixel of the first row only writes the center
// store; a drain before any full row is consumed with no result. The output
// register holds a finished result while the next transaction is taken. Line
// stores need no clearing after reset. Depends on mglap_pkg, mglap_in_if,
// mglap_out_if, mglap_ctrl, mglap_dp.
`default_nettype none

module masked_gradient_laplacian_stencil
  import mglap_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               frame_width_we,
  input  wire logic [FW_BITS-1:0] frame_width_data,
  mglap_in_if.sink                in_ch,
  mglap_out_if.source             out_ch
);

  localparam int IDX_BITS = $clog2(MAX_WIDTH);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [IDX_BITS-1:0] col;
  logic                in_ready;

  assign in_ch.ready = in_ready;

  mglap_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .frame_width_we   (frame_width_we),
    .frame_width_data (frame_width_data),
    .in_valid         (in_ch.valid),
    .in_action        (in_ch.action),
    .in_ready         (in_ready),
    .col              (col),
    .cmd              (cmd),
    .sts              (sts)
  );

  mglap_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .col            (col),
    .in_action      (in_ch.action),
    .in_sample      (in_ch.sample),
    .in_pixel_valid (in_ch.pixel_valid),
    .out_ch         (out_ch)
  );

endmodule

`default_nettype wire

// ===== test/tb_masked_gradient_laplacian_stencil.sv =====
`timescale 1ns / 100ps
// Testbench for masked_gradient_laplacian_stencil: drives raster and drain transactions,
// predicts every stencil result in a checker class and compares the output channel.
// Depends on mglap_pkg, mglap_in_if, mglap_out_if and the stencil RTL.

module tb_masked_gradient_laplacian_stencil;
  import mglap_pkg::*;

  localparam int LINE_DEPTH = 1024;

  typedef struct packed {
    bit [16:0]        gradient;
    bit signed [18:0] laplacian;
    bit               masked_out;
    bit               last_in_frame;
  } stencil_px_t;

  class stencil_checker;
    bit [16:0]   above_row [LINE_DEPTH];
    bit [16:0]   center_row [LINE_DEPTH];
    bit [16:0]   left_hold;
    int unsigned col;
    row_phase_t  phase;
    bit [10:0]   width_reg;
    stencil_px_t pending_pixels[$];
    int unsigned useful_items;
    int unsigned results_checked;
    int unsigned masked_seen;
    int unsigned errors;

    function new();
      foreach (above_row[i]) begin
        above_row[i] = '0;
        center_row[i] = '0;
      end
      left_hold = '0;
      col = 0;
      phase = PH_FIRST;
      width_reg = FW_RESET;
    endfunction

    function void set_width(bit [10:0] v);
      width_reg = v;
    endfunction

    function int unsigned used_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return 32'(width_reg);
    endfunction

    function bit [16:0] floor_root(longint unsigned s);
      longint unsigned r, t;
      r = 0;
      for (int i = 16; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= s) r = t;
      end
      return r[16:0];
    endfunction

    // Out-of-frame neighbors replicate the center; masked neighbors take the
    // center for the gradient but add nothing to the Laplacian sum.
    function stencil_px_t stencil_value(int unsigned c, int unsigned w, bit has_above,
                                        bit has_below, bit [16:0] below, bit last);
      bit [16:0]   ctr;
      bit [16:0]   nb [4];
      bit          pr [4];
      longint      gv [4];
      longint      cv, v, sum, dx, dy;
      stencil_px_t px;
      ctr = center_row[c];
      px = '0;
      px.last_in_frame = last;
      if (!ctr[16]) begin
        px.masked_out = 1'b1;
        return px;
      end
      cv = longint'($signed(ctr[15:0]));
      pr[0] = (c > 0);
      nb[0] = left_hold;
      pr[1] = (c + 1 < w);
      nb[1] = pr[1] ? center_row[c + 1] : '0;
      pr[2] = has_above;
      nb[2] = above_row[c];
      pr[3] = has_below;
      nb[3] = below;
      sum = 0;
      for (int k = 0; k < 4; k++) begin
        v = pr[k] ? longint'($signed(nb[k][15:0])) : cv;
        if (!pr[k] || nb[k][16]) begin
          gv[k] = v;
          sum += v;
        end else begin
          gv[k] = cv;
        end
      end
      dx = gv[1] - gv[0];
      dy = gv[3] - gv[2];
      px.gradient = floor_root(longint'(dx * dx + dy * dy));
      px.laplacian = 19'(sum - 4 * cv);
      return px;
    endfunction

    function void note_transaction(bit act, bit [15:0] smp, bit pv);
      bit [16:0]   entry;
      int unsigned w, c;
      bit          last;
      stencil_px_t px;
      entry = {pv, smp};
      w = used_width();
      c = (col >= LINE_DEPTH) ? 0 : col;
      last = (c + 1 >= w);
      if (act == ACT_DRAIN) begin
        if (phase == PH_FIRST) return;  // no full row yet: ignored
        useful_items++;
        px = stencil_value(c, w, phase == PH_LATER, 1'b0, '0, last);
        pending_pixels = {pending_pixels, px};
        left_hold = center_row[c];
        if (last) begin
          col = 0;
          phase = PH_FIRST;
        end else begin
          col = c + 1;
        end
        return;
      end
      useful_items++;
      if (phase == PH_FIRST) begin
        center_row[c] = entry;
        if (last) begin
          col = 0;
          phase = PH_SECOND;
        end else begin
          col = c + 1;
        end
        return;
      end
      px = stencil_value(c, w, phase == PH_LATER, 1'b1, entry, 1'b0);
      pending_pixels = {pending_pixels, px};
      above_row[c] = center_row[c];
      left_hold = center_row[c];
      center_row[c] = entry;
      if (last) begin
        col = 0;
        phase = PH_LATER;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_result(logic [16:0] g, logic signed [18:0] l, logic m, logic lst);
      stencil_px_t px;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result: gradient %0d laplacian %0d masked %0b last %0b",
                 $time, g, l, m, lst);
        errors++;
        return;
      end
      px = pending_pixels.pop_front();
      results_checked++;
      if (px.masked_out) masked_seen++;
      if (g !== px.gradient) begin
        $display("%0t: gradient expected %0d, actual %0d", $time, px.gradient, g);
        errors++;
      end
      if (l !== px.laplacian) begin
        $display("%0t: laplacian expected %0d, actual %0d", $time, px.laplacian, l);
        errors++;
      end
      if (m !== px.masked_out) begin
        $display("%0t: masked_out expected %0b, actual %0b", $time, px.masked_out, m);
        errors++;
      end
      if (lst !== px.last_in_frame) begin
        $display("%0t: last_in_frame expected %0b, actual %0b", $time, px.last_in_frame, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        frame_width_we = 1'b0;
  logic [10:0] frame_width_data = '0;
  bit          calm = 1'b0;
  int unsigned frames_run = 0;

  stencil_checker sb = new();

  mglap_in_if #(.SAMPLE_BITS(16)) in_ch ();
  mglap_out_if #(.SAMPLE_BITS(16)) out_ch ();

  masked_gradient_laplacian_stencil #(
    .MAX_WIDTH  (LINE_DEPTH),
    .SAMPLE_BITS(16)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .frame_width_we  (frame_width_we),
    .frame_width_data(frame_width_data),
    .in_ch           (in_ch),
    .out_ch          (out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.pending_pixels.size());
    $display("simulation failed");
    $finish;
  end

  // Result side: random backpressure, checks on the rising edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !rst && (calm || $urandom_range(0, 99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.gradient, out_ch.laplacian, out_ch.masked_out,
                      out_ch.last_in_frame);
  end

  function automatic bit [15:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back transactions need no re-raise.
  task automatic send_item(input bit act, input bit [15:0] smp, input bit pv);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.sample <= smp;
    in_ch.pixel_valid <= pv;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_transaction(act, smp, pv);
    @(negedge clk);
  endtask

  task automatic send_pixel();
    send_item(ACT_PIXEL, rand_sample(), $urandom_range(0, 99) < 85);
  endtask

  // Register writes only once the block has gone quiet.
  task automatic set_frame_width(input bit [10:0] v);
    in_ch.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    frame_width_we <= 1'b1;
    frame_width_data <= v;
    @(negedge clk);
    frame_width_we <= 1'b0;
    sb.set_width(v);
  endtask

  // Optional stray drains, full rows, then an optional partial row cut short by the drain.
  task automatic run_frame(input bit [10:0] w_reg, input int unsigned rows);
    int unsigned w, k, stray_at;
    w = (w_reg == 0) ? 1 : ((w_reg > LINE_DEPTH) ? LINE_DEPTH : 32'(w_reg));
    set_frame_width(w_reg);
    frames_run++;
    if ($urandom_range(0, 9) == 0)
      send_item(ACT_DRAIN, rand_sample(), 1'($urandom_range(0, 1)));
    stray_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w - 1) : w;
    for (int r = 0; r < rows; r++) begin
      for (int i = 0; i < w; i++) begin
        if (r == 0 && i == stray_at)
          send_item(ACT_DRAIN, rand_sample(), 1'($urandom_range(0, 1)));
        send_pixel();
      end
    end
    k = $urandom_range(0, 1) ? $urandom_range(0, w - 1) : 0;
    for (int i = 0; i < k; i++) send_pixel();
    for (int i = k; i < w; i++) send_item(ACT_DRAIN, rand_sample(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    bit [10:0] w_reg;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PIXEL;
    in_ch.sample = '0;
    in_ch.pixel_valid = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Drain with no row seen is dropped.
    send_item(ACT_DRAIN, 16'h0000, 1'b1);

    // 3x3 frame of extremes with masked neighbors and a masked center.
    set_frame_width(11'd3);
    send_item(ACT_PIXEL, 16'h7FFF, 1'b1);
    send_item(ACT_PIXEL, 16'h8000, 1'b1);
    send_item(ACT_PIXEL, 16'h8000, 1'b1);
    send_item(ACT_PIXEL, 16'h8000, 1'b1);
    send_item(ACT_PIXEL, 16'h7FFF, 1'b1);
    send_item(ACT_PIXEL, 16'h7FFF, 1'b0);
    send_item(ACT_PIXEL, 16'h7FFF, 1'b0);
    send_item(ACT_PIXEL, 16'h0000, 1'b1);
    send_item(ACT_PIXEL, 16'h8000, 1'b1);
    repeat (3) send_item(ACT_DRAIN, 16'hFFFF, 1'b0);

    // Width 0 behaves as a single column.
    set_frame_width(11'd0);
    send_item(ACT_PIXEL, 16'h0005, 1'b1);
    send_item(ACT_PIXEL, 16'hFFF9, 1'b1);
    send_item(ACT_DRAIN, 16'h0000, 1'b0);

    // Stray drain mid first row, then shrink so the next pixel ends the row.
    set_frame_width(11'd6);
    send_item(ACT_PIXEL, 16'h1234, 1'b1);
    send_item(ACT_PIXEL, 16'hEDCB, 1'b1);
    send_item(ACT_PIXEL, 16'h0FF0, 1'b0);
    send_item(ACT_PIXEL, 16'h7000, 1'b1);
    send_item(ACT_DRAIN, 16'h0000, 1'b1);
    set_frame_width(11'd2);
    send_item(ACT_PIXEL, 16'h4321, 1'b1);
    send_item(ACT_PIXEL, 16'h8001, 1'b1);
    send_item(ACT_DRAIN, 16'h0000, 1'b1);

    while (sb.useful_items < 850) begin
      calm = (frames_run >= 8 && frames_run < 20);
      case ($urandom_range(0, 15))
        0: w_reg = 11'd0;
        1: w_reg = 11'($urandom_range(13, 64));
        default: w_reg = 11'($urandom_range(1, 12));
      endcase
      run_frame(w_reg, $urandom_range(1, 4));
    end
    calm = 1'b0;

    // Over-range width acts as the maximum: one full row must end the first
    // row, then narrow to two columns and drain them.
    set_frame_width(11'd2047);
    frames_run++;
    repeat (LINE_DEPTH) send_pixel();
    set_frame_width(11'd2);
    repeat (2) send_item(ACT_DRAIN, rand_sample(), 1'($urandom_range(0, 1)));

    in_ch.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("%0d transactions with effect over %0d frames, widths 0 to 2047 written",
             sb.useful_items, frames_run);
    $display("%0d results checked, %0d of them masked centers",
             sb.results_checked, sb.masked_seen);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mglap_pkg.sv
src/mglap_in_if.sv
src/mglap_out_if.sv
src/mglap_sqrt.sv
src/mglap_ctrl.sv
src/mglap_dp.sv
src/masked_gradient_laplacian_stencil.sv
test/tb_masked_gradient_laplacian_stencil.sv
